[rtl/swmss_pkg.sv]
// ----------------------------------------------------------------------------
// swmss_pkg: shared types and constants of the stopwatch display block
// Register indexes, stage payload types, constant divider factors and the
// seven-segment font.
// ----------------------------------------------------------------------------
package swmss_pkg;

  localparam int CountW = 10;
  localparam int ScansW = 8;
  localparam int PosW   = 2;
  localparam int DigitsN = 4;
  localparam int SegW   = 7;
  localparam int CfgIndexW = 1;
  localparam int CfgDataW  = 10;

  // Register indexes of the configuration port.
  localparam logic [CfgIndexW-1:0] REG_SCANS_PER_COUNT = 1'b0;
  localparam logic [CfgIndexW-1:0] REG_COUNT_LIMIT     = 1'b1;

  localparam logic [ScansW-1:0] SCANS_RESET = 8'd50;
  localparam logic [CountW-1:0] LIMIT_RESET = 10'd999;

  // Scan positions, thousands digit first.
  localparam logic [PosW-1:0] POS_THOUSANDS = 2'd0;
  localparam logic [PosW-1:0] POS_HUNDREDS  = 2'd1;
  localparam logic [PosW-1:0] POS_TENS      = 2'd2;
  localparam logic [PosW-1:0] POS_UNITS     = 2'd3;

  // Reciprocal factors: (v * 205) >> 11 == v / 10 and (v * 41) >> 12 == v / 100
  // for every v below 1029.
  localparam int Div10Mul    = 205;
  localparam int Div10Shift  = 11;
  localparam int Div100Mul   = 41;
  localparam int Div100Shift = 12;
  localparam logic [CountW-1:0] THOUSAND = 10'd1000;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              run;
    logic [PosW-1:0]   pos;
  } tick_t;

  typedef struct packed {
    logic [SegW-1:0]    segments;
    logic [DigitsN-1:0] digit_enable;
    logic [CountW-1:0]  count_value;
    logic               is_running;
  } disp_t;

  function automatic logic [SegW-1:0] seg_of(input logic [3:0] digit);
    logic [SegW-1:0] pattern;
    case (digit)
      4'd0: pattern = 7'h3f;
      4'd1: pattern = 7'h06;
      4'd2: pattern = 7'h5b;
      4'd3: pattern = 7'h4f;
      4'd4: pattern = 7'h66;
      4'd5: pattern = 7'h6d;
      4'd6: pattern = 7'h7d;
      4'd7: pattern = 7'h07;
      4'd8: pattern = 7'h7f;
      default: pattern = 7'h67;
    endcase
    return pattern;
  endfunction

endpackage

[rtl/swmss_ctrl.sv]
// ----------------------------------------------------------------------------
// swmss_ctrl: stopwatch state update
// Holds the configuration registers, the run flag, count, scan position and
// scan tally, applies one tick per accepted word and registers the result.
// ----------------------------------------------------------------------------
module swmss_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swmss_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [swmss_pkg::CfgDataW-1:0]      cfg_data,
  input  logic                                tick_valid,
  output logic                                tick_ready,
  input  logic                                toggle_request,
  input  logic                                clear_request,
  output logic                                upd_valid,
  input  logic                                upd_ready,
  output swmss_pkg::tick_t                    upd
);
  import swmss_pkg::*;

  logic [ScansW-1:0] scans_per_count;
  logic [CountW-1:0] count_limit;
  logic [CountW-1:0] count;
  logic              run;
  logic [PosW-1:0]   pos;
  logic [ScansW-1:0] tally;

  logic [CountW-1:0] count_next;
  logic              run_next;
  logic [ScansW-1:0] tally_next;
  logic [ScansW:0]   tally_inc;
  logic [CountW:0]   count_inc;
  logic              accept;
  logic              run_toggled;

  assign cfg_ready  = 1'b1;
  assign tick_ready = !upd_valid || upd_ready;
  assign accept     = tick_valid && tick_ready;

  assign tally_inc   = {1'b0, tally} + (ScansW+1)'(1);
  assign count_inc   = {1'b0, count} + (CountW+1)'(1);
  assign run_toggled = run ^ toggle_request;

  always_comb begin
    count_next = count;
    run_next   = run_toggled;
    tally_next = tally;
    if (run_toggled && pos == POS_UNITS) begin
      // A zero scan setting passes this compare at once and acts as one.
      if (tally_inc >= {1'b0, scans_per_count}) begin
        tally_next = '0;
        if (count_inc > {1'b0, count_limit}) begin
          count_next = count_limit;
          run_next   = 1'b0;
        end else begin
          count_next = count_inc[CountW-1:0];
        end
      end else begin
        tally_next = tally_inc[ScansW-1:0];
      end
    end
    // Clear is checked after a possible stop, so it also applies then.
    if (clear_request && !run_next) begin
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scans_per_count <= SCANS_RESET;
      count_limit     <= LIMIT_RESET;
      count           <= '0;
      run             <= 1'b0;
      pos             <= POS_THOUSANDS;
      tally           <= '0;
      upd_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCANS_PER_COUNT: scans_per_count <= cfg_data[ScansW-1:0];
          REG_COUNT_LIMIT:     count_limit     <= cfg_data[CountW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        count     <= count_next;
        run       <= run_next;
        tally     <= tally_next;
        pos       <= pos + PosW'(1);
        upd_valid <= 1'b1;
      end else if (upd_ready) begin
        upd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      upd.count <= count_next;
      upd.run   <= run_next;
      upd.pos   <= pos;
    end
  end

`ifndef SYNTHESIS
  a_pos_steps: assert property (@(posedge clk) disable iff (rst)
    accept |=> pos == $past(pos) + PosW'(1))
    else $error("scan position did not advance on an accepted word");

  a_run_fell_on_tick: assert property (@(posedge clk) disable iff (rst)
    $fell(run) |-> $past(accept))
    else $error("run flag cleared without an accepted word");

  a_clear_when_paused: assert property (@(posedge clk) disable iff (rst)
    (accept && clear_request && !run_next) |=> count == '0)
    else $error("clear while paused left a nonzero count");
`endif

endmodule

[rtl/swmss_digit.sv]
// ----------------------------------------------------------------------------
// swmss_digit: digit extraction and segment decode
// Two registered stages: the first takes the decimal quotient for the
// scanned position, the second reduces it modulo ten, looks up the segment
// pattern and holds the finished display word.
// ----------------------------------------------------------------------------
module swmss_digit (
  input  logic              clk,
  input  logic              rst,
  input  logic              upd_valid,
  output logic              upd_ready,
  input  swmss_pkg::tick_t  upd,
  output logic              disp_valid,
  input  logic              disp_ready,
  output swmss_pkg::disp_t  disp
);
  import swmss_pkg::*;

  logic              quo_valid;
  logic              quo_ready;
  tick_t             quo_tick;
  logic [CountW-1:0] quo;

  logic [CountW-1:0] quo_sel;
  logic [21:0]       prod100;
  logic [21:0]       prod10;
  logic [21:0]       prod_mod;
  logic [CountW-1:0] quo_div10;
  logic [CountW-1:0] rem;
  logic [3:0]        digit;

  assign quo_ready = !disp_valid || disp_ready;
  assign upd_ready = !quo_valid || quo_ready;

  // Products are wide enough to hold every bit that the shifted selects read.
  assign prod100 = {12'd0, upd.count} * 22'(Div100Mul);
  assign prod10  = {12'd0, upd.count} * 22'(Div10Mul);

  always_comb begin
    case (upd.pos)
      POS_THOUSANDS: quo_sel = {{(CountW-1){1'b0}}, upd.count >= THOUSAND};
      POS_HUNDREDS:  quo_sel = prod100[Div100Shift +: CountW];
      POS_TENS:      quo_sel = prod10[Div10Shift +: CountW];
      default:       quo_sel = upd.count;
    endcase
  end

  // Remainder by ten of the registered quotient.
  assign prod_mod  = {12'd0, quo} * 22'(Div10Mul);
  assign quo_div10 = prod_mod[Div10Shift +: CountW];
  assign rem       = quo - ((quo_div10 << 3) + (quo_div10 << 1));
  assign digit     = (rem > 10'd9) ? 4'd9 : rem[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      quo_valid  <= 1'b0;
      disp_valid <= 1'b0;
    end else begin
      if (upd_valid && upd_ready) begin
        quo_valid <= 1'b1;
      end else if (quo_ready) begin
        quo_valid <= 1'b0;
      end
      if (quo_valid && quo_ready) begin
        disp_valid <= 1'b1;
      end else if (disp_ready) begin
        disp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_valid && upd_ready) begin
      quo_tick <= upd;
      quo      <= quo_sel;
    end
    if (quo_valid && quo_ready) begin
      disp.segments     <= seg_of(digit);
      disp.digit_enable <= DigitsN'(1) << quo_tick.pos;
      disp.count_value  <= quo_tick.count;
      disp.is_running   <= quo_tick.run;
    end
  end

`ifndef SYNTHESIS
  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    disp_valid |-> $onehot(disp.digit_enable))
    else $error("digit enable is not one-hot");

  a_units_quotient: assert property (@(posedge clk) disable iff (rst)
    (quo_valid && quo_tick.pos == POS_UNITS) |-> quo == quo_tick.count)
    else $error("units quotient differs from the count");

  a_quo_held: assert property (@(posedge clk) disable iff (rst)
    (quo_valid && !quo_ready) |=> quo_valid && $stable(quo))
    else $error("stalled quotient stage lost its word");
`endif

endmodule

[rtl/stopwatch_multiplexed_seven_segment.sv]
// ----------------------------------------------------------------------------
// stopwatch_multiplexed_seven_segment: four-digit multiplexed stopwatch
// One scan tick per input word, one display word per tick.
// ----------------------------------------------------------------------------
// The block takes one tick word per clock cycle when the output side keeps
// up, and each tick gives one display word after passing through its registers:
// one register for the stopwatch state update and two for the decimal digit
// decode. Up to three words are held inside while the output is stalled, so
// the input side keeps taking words until those stages are full. The
// configuration port is always ready; write it only while no tick is in
// flight.
module stopwatch_multiplexed_seven_segment (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swmss_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [swmss_pkg::CfgDataW-1:0]      cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [0] toggle_request, [1] clear_request, [7:2] zero
  input  logic [7:0]                          s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [6:0] segments, [10:7] digit_enable, [20:11] count_value,
  // [21] is_running, [23:22] zero
  output logic [23:0]                         m_tdata
);
  import swmss_pkg::*;

  logic  upd_valid;
  logic  upd_ready;
  tick_t upd;
  disp_t disp;

  swmss_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .tick_valid     (s_tvalid),
    .tick_ready     (s_tready),
    .toggle_request (s_tdata[0]),
    .clear_request  (s_tdata[1]),
    .upd_valid      (upd_valid),
    .upd_ready      (upd_ready),
    .upd            (upd)
  );

  swmss_digit u_digit (
    .clk        (clk),
    .rst        (rst),
    .upd_valid  (upd_valid),
    .upd_ready  (upd_ready),
    .upd        (upd),
    .disp_valid (m_tvalid),
    .disp_ready (m_tready),
    .disp       (disp)
  );

  assign m_tdata = {2'b00, disp.is_running, disp.count_value, disp.digit_enable,
                    disp.segments};

endmodule
